### sv/bptg_pkg.sv
// Shared types, widths and the tone interval table for the buzzer tone generator.
// No dependencies.
package bptg_pkg;

  localparam int unsigned TICKS_PER_MS = 16000;
  localparam int unsigned DurW  = 16;
  localparam int unsigned RemW  = 30;
  localparam int unsigned IdxW  = 4;
  localparam int unsigned CntW  = 14;
  localparam int unsigned IntW  = 11;
  localparam int unsigned VolW  = 2;
  localparam int unsigned Row0Len = 12;

  typedef enum logic [0:0] {
    CMD_TICK  = 1'b0,
    CMD_START = 1'b1
  } cmd_e;

  typedef struct packed {
    logic            pin_level;
    logic            output_enabled;
    logic            compare_event;
    logic [RemW-1:0] remaining_ticks;
  } result_t;

  typedef logic [IntW-1:0] tone_row_t [16];

  localparam tone_row_t TONE_ROW0 = '{
    11'd500, 11'd500, 11'd853, 11'd146, 11'd1853, 11'd146, 11'd500, 11'd500,
    11'd146, 11'd1853, 11'd146, 11'd853, 11'd0, 11'd0, 11'd0, 11'd0};
  localparam tone_row_t TONE_ROW1 = '{
    11'd500, 11'd500, 11'd782, 11'd217, 11'd900, 11'd100, 11'd782, 11'd217,
    11'd500, 11'd500, 11'd217, 11'd782, 11'd100, 11'd900, 11'd217, 11'd782};
  localparam tone_row_t TONE_ROW2 = '{
    11'd500, 11'd500, 11'd676, 11'd323, 11'd750, 11'd250, 11'd676, 11'd323,
    11'd500, 11'd500, 11'd323, 11'd676, 11'd250, 11'd750, 11'd323, 11'd676};

  // volume 3 shares the loudest row
  function automatic logic [IntW-1:0] tone_interval(input logic [VolW-1:0] vol,
                                                    input logic [IdxW-1:0] idx);
    logic [IntW-1:0] val;
    case (vol)
      2'd0:    val = TONE_ROW0[idx];
      2'd1:    val = TONE_ROW1[idx];
      default: val = TONE_ROW2[idx];
    endcase
    return val;
  endfunction

endpackage

### sv/bptg_if.sv
// Valid/ready channel interfaces for the buzzer tone generator: command in, result out.
// Depends on bptg_pkg.
interface bptg_in_if import bptg_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            command;
  logic [DurW-1:0] duration_ms;

  modport source(output valid, command, duration_ms, input ready);
  modport sink(input valid, command, duration_ms, output ready);
endinterface

interface bptg_out_if import bptg_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            pin_level;
  logic            output_enabled;
  logic            compare_event;
  logic [RemW-1:0] remaining_ticks;

  modport source(output valid, pin_level, output_enabled, compare_event, remaining_ticks,
                 input ready);
  modport sink(input valid, pin_level, output_enabled, compare_event, remaining_ticks,
               output ready);
endinterface

### sv/buzzer_pattern_tone_generator.sv
// Buzzer tone generator top level: tick/start handling, tone table stepping, output buffer.
// Depends on bptg_pkg and the channel interfaces in bptg_if.sv.
//
//   channel   dir  handshake            payload
//   in_ch     in   valid/ready          command, duration_ms
//   out_ch    out  valid/ready          pin_level, output_enabled, compare_event,
//                                       remaining_ticks
//   cfg       in   cfg_we_i             cfg_wdata_i (volume)
//
// One item per cycle while in_ch is ready; each result is registered into the output register,
// or into the skid entry while the output register holds a stalled result.
// A two-entry output buffer (output register plus skid) keeps in_ch open while one
// result waits; in_ch stalls only when both entries are full.
// Reset: countdown loads TICKS_PER_MS, the other state and both buffer valid flags clear, driver disabled.
module buzzer_pattern_tone_generator import bptg_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  bptg_in_if.sink         in_ch,
  bptg_out_if.source      out_ch,
  input  logic            cfg_we_i,
  input  logic [VolW-1:0] cfg_wdata_i
);

  logic [VolW-1:0] vol_q;
  logic [RemW-1:0] rem_q, rem_d;
  logic [IdxW-1:0] idx_q, idx_d, idx_nxt;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pin_q, pin_d;
  logic            drv_q, drv_d;
  logic            evt;

  logic            push, pop, start, expire;
  logic [IntW-1:0] step;
  logic [IdxW:0]   idx_inc;
  logic [RemW-1:0] rem_sub, prod;
  result_t         res;

  result_t         main_q, main_d, skid_q, skid_d;
  logic            main_vld_q, main_vld_d, skid_vld_q, skid_vld_d;

  assign push   = in_ch.valid && in_ch.ready;
  assign pop    = out_ch.valid && out_ch.ready;
  assign start  = (in_ch.command == CMD_START);
  assign expire = (cnt_q <= CntW'(1));
  assign step   = tone_interval(vol_q, idx_q);

  assign idx_inc = {1'b0, idx_q} + (IdxW+1)'(1);
  always_comb begin
    if (vol_q == '0) begin
      idx_nxt = (idx_inc >= (IdxW+1)'(Row0Len)) ? IdxW'(idx_inc - (IdxW+1)'(Row0Len))
                                                 : IdxW'(idx_inc);
    end else begin
      idx_nxt = idx_inc[IdxW-1:0];
    end
  end

  assign rem_sub = (rem_q >= RemW'(step)) ? rem_q - RemW'(step) : '0;
  assign prod    = RemW'(in_ch.duration_ms) * RemW'(TICKS_PER_MS);

  always_comb begin
    rem_d = rem_q;
    idx_d = idx_q;
    cnt_d = cnt_q;
    pin_d = pin_q;
    drv_d = drv_q;
    evt   = 1'b0;
    if (push) begin
      if (start) begin
        rem_d = prod;
        drv_d = 1'b1;
      end else if (!expire) begin
        cnt_d = cnt_q - CntW'(1);
      end else begin
        evt   = 1'b1;
        pin_d = ~pin_q;
        if (rem_q != '0) begin
          rem_d = rem_sub;
        end else begin
          drv_d = 1'b0;
        end
        idx_d = idx_nxt;
        cnt_d = CntW'(tone_interval(vol_q, idx_nxt));
      end
    end
  end

  assign res = '{pin_level: pin_d, output_enabled: drv_d, compare_event: evt,
                 remaining_ticks: rem_d};

  // two-entry output buffer; skid only fills while the head is stalled
  always_comb begin
    main_d     = main_q;
    skid_d     = skid_q;
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    if (pop || !main_vld_q) begin
      main_vld_d = skid_vld_q || push;
      if (skid_vld_q) begin
        main_d     = skid_q;
        skid_d     = res;
        skid_vld_d = push;
      end else begin
        main_d     = res;
        skid_vld_d = 1'b0;
      end
    end else if (push) begin
      skid_d     = res;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q      <= '0;
      rem_q      <= '0;
      idx_q      <= '0;
      cnt_q      <= CntW'(TICKS_PER_MS);
      pin_q      <= 1'b0;
      drv_q      <= 1'b0;
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        vol_q <= cfg_wdata_i;
      end
      rem_q      <= rem_d;
      idx_q      <= idx_d;
      cnt_q      <= cnt_d;
      pin_q      <= pin_d;
      drv_q      <= drv_d;
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign in_ch.ready            = !skid_vld_q;
  assign out_ch.valid           = main_vld_q;
  assign out_ch.pin_level       = main_q.pin_level;
  assign out_ch.output_enabled  = main_q.output_enabled;
  assign out_ch.compare_event   = main_q.compare_event;
  assign out_ch.remaining_ticks = main_q.remaining_ticks;

  a_skid_behind_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> main_vld_q)
    else $error("skid entry valid with empty output register");

  a_start_enables: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && start) |=> drv_q)
    else $error("start transfer did not enable the driver");

  a_row0_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !start && expire && vol_q == '0) |=> (idx_q < IdxW'(Row0Len)))
    else $error("row 0 index not wrapped below twelve");

  a_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !start && expire) |=> (cnt_q == CntW'(tone_interval($past(vol_q), idx_q))))
    else $error("countdown not reloaded from the interval table");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && !pop) |=> skid_vld_q)
    else $error("buffered result dropped while output stalled");

endmodule

### verif/tb.sv
// Self-checking bench for buzzer_pattern_tone_generator: ticks and start commands in,
// per-item pin/driver/remaining-time results out, checked against an in-bench tone model.
// Depends on bptg_pkg, the channel interfaces in bptg_if.sv and the top level.
`timescale 1ns / 100ps

module tb;
  import bptg_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned SWEEP_ITEMS  = 25_000;
  localparam int unsigned MIX_BLOCKS   = 8;
  localparam int unsigned MIX_ITEMS    = 250;
  localparam int unsigned ROW_LEN      = 16;
  localparam int unsigned TOP_ROW      = 2;
  localparam logic [VolW-1:0] VOL_MIN  = 2'd0;
  localparam logic [VolW-1:0] VOL_MAX  = 2'd3;
  localparam logic [7:0] STALL_PAT     = 8'b1011_0110;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [VolW-1:0] cfg_wdata_i;

  bptg_in_if  in_ch ();
  bptg_out_if out_ch ();

  buzzer_pattern_tone_generator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // toggle intervals per volume row; row 0 only walks its first twelve entries
  int unsigned tone_steps [3][16] = '{
    '{500, 500, 853, 146, 1853, 146, 500, 500, 146, 1853, 146, 853, 0, 0, 0, 0},
    '{500, 500, 782, 217, 900, 100, 782, 217, 500, 500, 217, 782, 100, 900, 217, 782},
    '{500, 500, 676, 323, 750, 250, 676, 323, 500, 500, 323, 676, 250, 750, 323, 676}
  };

  // tone model state
  logic [VolW-1:0] volume_q = '0;
  logic [RemW-1:0] remain_q = '0;
  logic [IdxW-1:0] index_q  = '0;
  logic [CntW-1:0] count_q  = CntW'(TICKS_PER_MS);
  logic            pin_q    = 1'b0;
  logic            drive_q  = 1'b0;

  result_t tone_results_q [$];
  result_t want;

  int unsigned errors    = 0;
  int unsigned checked   = 0;
  int unsigned sent      = 0;
  int unsigned expiries  = 0;
  int unsigned burst_left = 0;
  int unsigned cycle_cnt = 0;
  bit          idle_en   = 1'b1;

  function automatic void advance_tone(input cmd_e cmd, input logic [DurW-1:0] dur);
    result_t     res;
    int unsigned row;
    int unsigned step;
    logic        hit;
    hit = 1'b0;
    if (cmd == CMD_START) begin
      remain_q = RemW'(longint'(dur) * longint'(TICKS_PER_MS));
      drive_q  = 1'b1;
    end else if (count_q > 1) begin
      count_q = count_q - 1'b1;
    end else begin
      row  = (volume_q > TOP_ROW) ? TOP_ROW : volume_q;
      step = tone_steps[row][index_q];
      hit  = 1'b1;
      pin_q = ~pin_q;
      if (remain_q != '0) begin
        remain_q = (remain_q >= step) ? remain_q - RemW'(step) : '0;
      end else begin
        drive_q = 1'b0;
      end
      index_q = IdxW'((index_q + 1) % ((row == 0) ? Row0Len : ROW_LEN));
      count_q = CntW'(tone_steps[row][index_q]);
      expiries++;
    end
    res.pin_level       = pin_q;
    res.output_enabled  = drive_q;
    res.compare_event   = hit;
    res.remaining_ticks = remain_q;
    tone_results_q.push_back(res);
  endfunction

  function automatic void compare_field(input string name, input logic [RemW-1:0] exp_v,
                                        input logic [RemW-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // one item per call; the sender may pause between bursts of random length
  task automatic send_cmd(input cmd_e cmd, input logic [DurW-1:0] dur);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 64);
      gap = idle_en ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.duration_ms <= dur;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent++;
    advance_tone(cmd, dur);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (tone_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_volume(input logic [VolW-1:0] vol);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= vol;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    volume_q = vol;
  endtask

  task automatic test_directed();
    send_cmd(CMD_TICK, 16'hFFFF);
    send_cmd(CMD_START, 16'h0000);
    send_cmd(CMD_TICK, 16'h0000);
    send_cmd(CMD_START, 16'hFFFF);
    send_cmd(CMD_TICK, 16'h5555);
    send_cmd(CMD_START, 16'h0001);
    send_cmd(CMD_START, 16'h5555);
    send_cmd(CMD_START, 16'hAAAA);
    send_cmd(CMD_TICK, 16'hAAAA);
    send_cmd(CMD_START, 16'h0002);
    send_cmd(CMD_TICK, 16'h0001);
    set_volume(VOL_MAX);
    send_cmd(CMD_TICK, 16'h8000);
    send_cmd(CMD_START, 16'h7FFF);
    send_cmd(CMD_TICK, 16'h0000);
  endtask

  // long tick runs so the countdown expires many times; rare restarts
  task automatic test_volume_sweep(input logic [VolW-1:0] vol);
    logic [DurW-1:0] dur;
    set_volume(vol);
    send_cmd(CMD_START, 16'd1);
    for (int unsigned i = 0; i < SWEEP_ITEMS; i++) begin
      idle_en = ((i >> 12) % 3) != 2;
      if ($urandom_range(0, 2047) == 0) begin
        case ($urandom_range(0, 2))
          0:       dur = '0;
          1:       dur = DurW'($urandom_range(1, 2));
          default: dur = DurW'($urandom);
        endcase
        send_cmd(CMD_START, dur);
      end else begin
        send_cmd(CMD_TICK, DurW'($urandom));
      end
    end
    idle_en = 1'b1;
  endtask

  // walk the index into 12..15 on a sixteen-entry row, then fall back to row 0
  task automatic test_index_past_row0();
    for (int unsigned pass = 0; pass < 2; pass++) begin
      set_volume(2'd1);
      send_cmd(CMD_START, DurW'(pass));
      while (index_q < Row0Len) send_cmd(CMD_TICK, DurW'($urandom));
      set_volume(VOL_MIN);
      while (index_q >= Row0Len) send_cmd(CMD_TICK, DurW'($urandom));
    end
  endtask

  task automatic test_random_mix();
    for (int unsigned blk = 0; blk < MIX_BLOCKS; blk++) begin
      set_volume(VolW'($urandom_range(0, 3)));
      for (int unsigned i = 0; i < MIX_ITEMS; i++) begin
        if ($urandom_range(0, 7) == 0) send_cmd(CMD_START, DurW'($urandom));
        else send_cmd(CMD_TICK, DurW'($urandom));
      end
    end
  endtask

  // receiver stall pattern plus run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    case (cycle_cnt[10:9])
      2'd0:    out_ch.ready <= 1'b1;
      2'd1:    out_ch.ready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_ch.ready <= STALL_PAT[cycle_cnt[2:0]];
      default: out_ch.ready <= 1'($urandom_range(0, 1));
    endcase
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (tone_results_q.size() == 0) begin
        $display("%0t: result with nothing pending, expected none actual %s%b %s%b %s%b %s%0d",
                 $time, "pin=", out_ch.pin_level, "en=", out_ch.output_enabled,
                 "ev=", out_ch.compare_event, "rem=", out_ch.remaining_ticks);
        errors++;
      end else begin
        want = tone_results_q.pop_front();
        compare_field("pin_level", RemW'(want.pin_level), RemW'(out_ch.pin_level));
        compare_field("output_enabled", RemW'(want.output_enabled),
                      RemW'(out_ch.output_enabled));
        compare_field("compare_event", RemW'(want.compare_event), RemW'(out_ch.compare_event));
        compare_field("remaining_ticks", want.remaining_ticks, out_ch.remaining_ticks);
        checked++;
      end
    end
  end

  initial begin
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.command     <= CMD_TICK;
    in_ch.duration_ms <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    for (int unsigned v = VOL_MIN; v <= VOL_MAX; v++) test_volume_sweep(VolW'(v));
    test_index_past_row0();
    test_random_mix();

    drain_results();
    $display("Sent %0d commands, checked %0d results, %0d interval expiries", sent, checked,
             expiries);
    $display("Volumes 0 to 3, index past row 0 length, restarts and driver shutoff exercised");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
sv/bptg_pkg.sv
sv/bptg_if.sv
sv/buzzer_pattern_tone_generator.sv
verif/tb.sv
